// ----- rtl/mmcs_pkg.sv -----
package mmcs_pkg;

  localparam int PIXEL_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int PIX_W     = 16;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_APPLY   = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel;
    logic             first_of_frame;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] scaled_pixel;
    logic             divide_error;
  } out_word_t;

endpackage

// ----- rtl/min_max_contrast_stretch.sv -----
// Min-max contrast stretch of unsigned pixels.
// Input channel in_valid/in_stall/in_data carries one word per pixel. A
// measure word (req_type 0) updates the tracked min and max registers;
// first_of_frame restarts both from that pixel. Measure words give no result.
// An apply word (req_type 1) gives one result word on out_valid/out_data,
// held while out_stall is high: the pixel clamped to the measured range,
// less min, scaled by |range_high-range_low| over (max-min), 8 fraction bits.
// An apply word starts the serial divider through start_r; it forms the
// product, loads it, then forms one quotient bit per cycle; the quotient
// goes to the result register, then to the output register. In identity
// (min, max equal to range_low, range_high: pixel shifted by the fraction
// bits) and flat-frame (max <= min: 0 with divide_error) cases the divider
// is skipped. One word is in work at a time; in_stall is high until the
// result is in the output register, which frees the input while the receiver
// stalls; the next word can be taken the cycle after, and measure words one per cycle while idle.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken;
// write them only while no apply word is in work.
// Synchronous reset sets min to all ones, max to 0, range_low 0,
// range_high all ones, and empties the output register.
module min_max_contrast_stretch
#(
  parameter int PIXEL_BITS    = mmcs_pkg::PIXEL_BITS_DEF,
  parameter int FRACTION_BITS = mmcs_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mmcs_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mmcs_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmcs_pkg::CFG_W-1:0]     cfg_data
);
  import mmcs_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int SW = PIXEL_BITS + FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [P-1:0]  range_low_r, range_high_r;
  logic [P-1:0]  min_r, max_r;
  logic [P-1:0]  span_r, d_r, den_r;
  logic          start_r;
  out_word_t     res_r;
  logic          out_valid_r;
  out_word_t     out_data_r;

  logic          in_acc;
  logic          out_free;
  logic [P-1:0]  x;
  logic [P-1:0]  xc;
  logic          ident;
  logic          flat;
  logic          div_done;
  logic [SW-1:0] quot;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign x        = in_data.pixel[P-1:0];
  assign ident    = (min_r == range_low_r) && (max_r == range_high_r);
  assign flat     = (max_r <= min_r);

  always_comb begin
    priority if (x < min_r) begin
      xc = min_r;
    end else if (x > max_r) begin
      xc = max_r;
    end else begin
      xc = x;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.req_type == REQ_APPLY)) begin
          state_nxt = (ident || flat) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      range_low_r  <= '0;
      range_high_r <= '1;
      min_r        <= '1;
      max_r        <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc && (in_data.req_type == REQ_APPLY) && !ident && !flat;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RANGE_LOW) begin
          range_low_r <= cfg_data[P-1:0];
        end else if (cfg_index == REG_RANGE_HIGH) begin
          range_high_r <= cfg_data[P-1:0];
        end
      end
      if (in_acc && (in_data.req_type == REQ_MEASURE)) begin
        if (in_data.first_of_frame) begin
          min_r <= x;
          max_r <= x;
        end else begin
          if (x < min_r) begin
            min_r <= x;
          end
          if (x > max_r) begin
            max_r <= x;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.req_type == REQ_APPLY)) begin
      span_r <= (range_high_r >= range_low_r) ? (range_high_r - range_low_r)
                                              : (range_low_r - range_high_r);
      d_r    <= xc - min_r;
      den_r  <= max_r - min_r;
      if (ident) begin
        res_r.scaled_pixel <= OUT_W'(SW'(x) << FRACTION_BITS);
        res_r.divide_error <= 1'b0;
      end else begin
        res_r.scaled_pixel <= '0;
        res_r.divide_error <= flat;
      end
    end else if ((state_r == ST_DIV) && div_done) begin
      res_r.scaled_pixel <= OUT_W'(quot);
      res_r.divide_error <= 1'b0;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= res_r;
    end
  end

  mmcs_div #(
    .PIXEL_BITS    (PIXEL_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .mul_a (span_r),
    .mul_b (d_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- rtl/mmcs_div.sv -----
module mmcs_div #(
  parameter int PIXEL_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [PIXEL_BITS-1:0]               mul_a,
  input  logic [PIXEL_BITS-1:0]               mul_b,
  input  logic [PIXEL_BITS-1:0]               den,
  output logic                                done,
  output logic [PIXEL_BITS+FRACTION_BITS-1:0] quot
);
  localparam int P  = PIXEL_BITS;
  localparam int SW = PIXEL_BITS + FRACTION_BITS;
  localparam int PW = 2 * PIXEL_BITS;
  localparam int CW = $clog2(SW);

  logic [PW-1:0] prod_r;
  logic [P-1:0]  den_r;
  logic [P-1:0]  rem_r;
  logic [SW-1:0] sh_r;
  logic [CW-1:0] cnt_r;
  logic          load_r;
  logic          busy_r;
  logic          done_r;

  logic [P:0]    rem2;
  logic [P:0]    diff;
  logic          ge;
  logic [P-1:0]  rem_nxt;
  logic [SW-1:0] sh_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem2    = {rem_r, sh_r[SW-1]};
    ge      = (rem2 >= {1'b0, den_r});
    diff    = rem2 - {1'b0, den_r};
    rem_nxt = ge ? diff[P-1:0] : rem2[P-1:0];
    sh_nxt  = {sh_r[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        load_r <= 1'b1;
        busy_r <= 1'b0;
      end else if (load_r) begin
        load_r <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(SW - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
      den_r  <= den;
    end else if (load_r) begin
      // top bits of the numerator are known to stay below den
      rem_r <= prod_r[PW-1:P];
      sh_r  <= SW'(prod_r[P-1:0]) << FRACTION_BITS;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

// ----- rtl/mmcs_checker.sv -----
module mmcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mmcs_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mmcs_pkg::out_word_t out_data
);
  import mmcs_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // error words carry zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |-> out_data.scaled_pixel == '0)
    else $error("error word with nonzero pixel");

  // apply word keeps the input busy
  a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_APPLY) |=> in_stall)
    else $error("input free right after apply word");

  // measure word makes no result
  a_measure_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_MEASURE) && !out_valid
    |=> !out_valid)
    else $error("result after measure word");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall left after reset");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/min_max_contrast_stretch_chk.sv -----
`timescale 1ns / 1ps

module min_max_contrast_stretch_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  mmcs_pkg::in_word_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  mmcs_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmcs_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             words_pending,
  output int                             results_checked,
  output int                             flagged_results
);
  import mmcs_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;

  logic [PIX_W-1:0] range_lo;
  logic [PIX_W-1:0] range_hi;
  logic [PIX_W-1:0] min_seen;
  logic [PIX_W-1:0] max_seen;
  out_word_t        scaled_q[$];

  function automatic out_word_t stretch_pixel(input logic [PIX_W-1:0] x);
    out_word_t        w;
    logic [39:0]      wide;
    logic [PIX_W-1:0] xc;
    logic [PIX_W-1:0] span;
    logic [PIX_W-1:0] den;
    w.divide_error = 1'b0;
    if (min_seen == range_lo && max_seen == range_hi) begin
      wide = 40'(x) << FRAC;
      w.scaled_pixel = wide[OUT_W-1:0];
    end else if (max_seen <= min_seen) begin
      w.scaled_pixel = '0;
      w.divide_error = 1'b1;
    end else begin
      xc = x;
      if (xc < min_seen) xc = min_seen;
      if (xc > max_seen) xc = max_seen;
      span = (range_hi >= range_lo) ? range_hi - range_lo : range_lo - range_hi;
      den = max_seen - min_seen;
      wide = 40'(span) * 40'(xc - min_seen);
      wide = (wide << FRAC) / 40'(den);
      w.scaled_pixel = wide[OUT_W-1:0];
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      range_lo = '0;
      range_hi = '1;
      min_seen = '1;
      max_seen = '0;
      scaled_q.delete();
      mismatches <= 0;
      results_checked <= 0;
      flagged_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_LOW: begin
            range_lo = cfg_data[PIX_W-1:0];
          end
          REG_RANGE_HIGH: begin
            range_hi = cfg_data[PIX_W-1:0];
          end
          default: ;
        endcase
      end
      // results leave before the new word is predicted
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          $display("%0t: result word %h/%0b with nothing expected", $time,
                   out_data.scaled_pixel, out_data.divide_error);
          mismatches <= mismatches + 1;
        end else begin
          want = scaled_q.pop_front();
          if (out_data.scaled_pixel !== want.scaled_pixel ||
              out_data.divide_error !== want.divide_error) begin
            $display("%0t: result mismatch, expected %h/%0b, got %h/%0b", $time,
                     want.scaled_pixel, want.divide_error,
                     out_data.scaled_pixel, out_data.divide_error);
            mismatches <= mismatches + 1;
          end
          results_checked <= results_checked + 1;
          if (out_data.divide_error) flagged_results <= flagged_results + 1;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_MEASURE) begin
          if (in_data.first_of_frame) begin
            min_seen = in_data.pixel;
            max_seen = in_data.pixel;
          end else begin
            if (in_data.pixel < min_seen) min_seen = in_data.pixel;
            if (in_data.pixel > max_seen) max_seen = in_data.pixel;
          end
        end else begin
          scaled_q.push_back(stretch_pixel(in_data.pixel));
        end
      end
    end
    words_pending <= scaled_q.size();
  end

endmodule

// ----- tb/sv/min_max_contrast_stretch_tb.sv -----
`timescale 1ns / 1ps

module min_max_contrast_stretch_tb;
  import mmcs_pkg::*;

  localparam int ITEMS         = 1700;
  localparam int SETTLE_CYCLES = 40;
  localparam int STUCK_LIMIT   = 3000;
  localparam int PIX_MAX       = 65535;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RANGE_LOW;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatches;
  int words_pending;
  int results_checked;
  int flagged_results;
  int words_sent   = 0;
  int reg_writes   = 0;
  int stuck_cycles = 0;
  int stall_left   = 0;
  int cur_lo       = 0;
  int cur_hi       = PIX_MAX;
  bit quiet        = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  min_max_contrast_stretch dut (.*);

  min_max_contrast_stretch_chk chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, stuck_cycles);
      $display("min_max_contrast_stretch_tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_pixel(input logic req, input int pix, input logic first);
    in_word_t w;
    int       gap;
    w.req_type       = req;
    w.pixel          = pix[PIX_W-1:0];
    w.first_of_frame = first;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic write_range(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_RANGE_LOW) cur_lo = value;
    else cur_hi = value;
  endtask

  task automatic set_range(input int lo, input int hi);
    write_range(REG_RANGE_LOW, lo);
    write_range(REG_RANGE_HIGH, hi);
  endtask

  // drain all results, then give a trailing word time to finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_frame();
    int kind;
    int n;
    int m;
    int lo_p;
    int hi_p;
    int spread;
    int pos_lo;
    int pos_hi;
    int pix;
    kind = $urandom_range(9, 0);
    lo_p = $urandom_range(PIX_MAX, 0);
    case ($urandom_range(2, 0))
      0: spread = $urandom_range(4, 1);
      1: spread = $urandom_range(255, 0);
      default: spread = $urandom_range(PIX_MAX, 0);
    endcase
    hi_p = (lo_p + spread > PIX_MAX) ? PIX_MAX : lo_p + spread;
    // frame spanning exactly the target range
    if ((kind == 6 || kind == 7) && cur_lo <= cur_hi) begin
      lo_p = cur_lo;
      hi_p = cur_hi;
    end
    if (kind == 8) hi_p = lo_p;
    if (kind == 9) begin
      n = $urandom_range(16, 1);
      for (int i = 0; i < n; i++) begin
        send_pixel(1'($urandom_range(1, 0)), $urandom_range(PIX_MAX, 0),
                   $urandom_range(3, 0) == 0);
      end
    end else begin
      n = $urandom_range(10, 2);
      pos_lo = $urandom_range(n - 1, 0);
      pos_hi = (pos_lo + $urandom_range(n - 1, 1)) % n;
      for (int i = 0; i < n; i++) begin
        if (i == pos_lo) pix = lo_p;
        else if (i == pos_hi) pix = hi_p;
        else pix = $urandom_range(hi_p, lo_p);
        send_pixel(REQ_MEASURE, pix, i == 0);
      end
      m = $urandom_range(12, 1);
      for (int i = 0; i < m; i++) begin
        if ($urandom_range(9, 0) < 3) pix = $urandom_range(PIX_MAX, 0);
        else pix = $urandom_range((hi_p + 8 > PIX_MAX) ? PIX_MAX : hi_p + 8,
                                  (lo_p < 8) ? 0 : lo_p - 8);
        send_pixel(REQ_APPLY, pix, 1'($urandom_range(1, 0)));
      end
    end
  endtask

  initial begin : stimulus
    int v;
    int nframes;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // untouched min and max after reset
    send_pixel(REQ_APPLY, 0, 1'b0);
    send_pixel(REQ_APPLY, PIX_MAX, 1'b1);
    settle();
    // reversed range matches the reset min and max
    set_range(PIX_MAX, 0);
    send_pixel(REQ_APPLY, 'h00ab, 1'b0);
    send_pixel(REQ_MEASURE, 100, 1'b1);
    send_pixel(REQ_APPLY, 100, 1'b0);
    settle();
    // flat frame equal to a flat range, then zero span
    set_range(100, 100);
    send_pixel(REQ_APPLY, 7, 1'b0);
    send_pixel(REQ_MEASURE, 0, 1'b0);
    send_pixel(REQ_APPLY, 50, 1'b0);
    settle();
    set_range(0, PIX_MAX);
    send_pixel(REQ_MEASURE, 0, 1'b1);
    send_pixel(REQ_MEASURE, PIX_MAX, 1'b0);
    send_pixel(REQ_APPLY, 0, 1'b0);
    send_pixel(REQ_APPLY, PIX_MAX, 1'b0);
    send_pixel(REQ_APPLY, 'h1234, 1'b0);
    send_pixel(REQ_MEASURE, 1000, 1'b1);
    send_pixel(REQ_MEASURE, 3000, 1'b0);
    send_pixel(REQ_APPLY, 500, 1'b0);
    send_pixel(REQ_APPLY, 4000, 1'b0);
    send_pixel(REQ_APPLY, 2000, 1'b1);
    send_pixel(REQ_APPLY, 1000, 1'b0);
    send_pixel(REQ_APPLY, 3000, 1'b0);
    settle();

    while (words_sent < ITEMS) begin
      quiet = ($urandom_range(3, 0) == 0);
      v = $urandom_range(PIX_MAX, 0);
      case ($urandom_range(5, 0))
        0: set_range(0, PIX_MAX);
        1: set_range(PIX_MAX, 0);
        2: set_range(v, $urandom_range(PIX_MAX, 0));
        3: set_range(v, v);
        4: set_range(v, (v + 300 > PIX_MAX) ? PIX_MAX : v + $urandom_range(300, 1));
        default: set_range(v, PIX_MAX);
      endcase
      nframes = $urandom_range(6, 2);
      for (int f = 0; f < nframes; f++) run_frame();
      settle();
    end

    $display("covered %0d pixel words over %0d register writes", words_sent, reg_writes);
    $display("compared %0d results, %0d of them divide errors",
             results_checked, flagged_results);
    if (mismatches == 0 && words_pending == 0) begin
      $display("min_max_contrast_stretch_tb: done, clean");
    end else begin
      $display("min_max_contrast_stretch_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mmcs_pkg.sv
rtl/mmcs_div.sv
rtl/min_max_contrast_stretch.sv
rtl/mmcs_checker.sv
tb/sv/min_max_contrast_stretch_chk.sv
tb/sv/min_max_contrast_stretch_tb.sv
